// ===== hw/rtl/rrug_pkg.sv =====
// rrug_pkg: shared types and constants of the round-robin upstream grant core
// used by rrug_front, rrug_back and the top level; depends on nothing
package rrug_pkg;

    // fixed field widths
    localparam int IDX_W     = 4;
    localparam int WORDS_W   = 16;
    localparam int BYTES_W   = 18;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 1;

    // opcodes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SERVICE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONN_COUNT  = 1'd1;

    // register reset values
    localparam logic [BYTES_W-1:0] MAX_SERVICE_RESET = 18'd4096;

    // depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // classified command handed from front to back
    typedef struct packed {
        logic               opcode;
        logic               wr_en;
        logic [IDX_W-1:0]   conn_index;
        logic [WORDS_W-1:0] queue_words;
        logic [WORDS_W-1:0] frag_words;
        logic               seg_running;
    } cmd_t;

    // one status table entry
    typedef struct packed {
        logic               seg_running;
        logic [WORDS_W-1:0] frag_words;
        logic [WORDS_W-1:0] queue_words;
    } entry_t;

    // one result transaction
    typedef struct packed {
        logic               granted;
        logic [IDX_W-1:0]   grant_index;
        logic [BYTES_W-1:0] grant_bytes;
    } res_t;

    // back-end sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LAST,
        S_SCAN
    } back_state_t;

endpackage

// ===== hw/rtl/rrug_ram.sv =====
// rrug_ram: generic single-write, single-read RAM with registered read data
// standalone; no package needed
module rrug_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rrug_front.sv =====
// rrug_front: accepts input transactions, classifies them and queues them
// depends on rrug_pkg
module rrug_front #(
    parameter int MAX_CONNS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [rrug_pkg::IDX_W-1:0]    s_conn_index,
    input  logic [rrug_pkg::WORDS_W-1:0]  s_queue_words,
    input  logic [rrug_pkg::WORDS_W-1:0]  s_frag_words,
    input  logic                          s_seg_running,
    output logic                          q_valid,
    output rrug_pkg::cmd_t                q_cmd,
    input  logic                          q_pop
);
    import rrug_pkg::*;

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC = $clog2(QUEUE_DEPTH + 1);

    cmd_t          q_mem_reg [QUEUE_DEPTH];
    logic [QW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC-1:0] count_reg, count_next;
    cmd_t          cmd_in;
    logic          push;

    // classify: updates outside the table are acknowledged but not written
    always_comb begin
        cmd_in.opcode      = s_opcode;
        cmd_in.wr_en       = (s_opcode == OP_UPDATE) && (32'(s_conn_index) < MAX_CONNS);
        cmd_in.conn_index  = s_conn_index;
        cmd_in.queue_words = s_queue_words;
        cmd_in.frag_words  = s_frag_words;
        cmd_in.seg_running = s_seg_running;
    end

    assign s_ready = (count_reg < QC'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_cmd   = q_mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (q_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QC'(QUEUE_DEPTH))
        else $error("command queue overfilled");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !q_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a pushed transaction");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && !push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count kept a popped transaction");

endmodule

// ===== hw/rtl/rrug_back.sv =====
// rrug_back: executes queued commands against the status table, runs the
// round-robin scan and holds the result register; depends on rrug_pkg, rrug_ram
module rrug_back #(
    parameter int MAX_CONNS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  q_valid,
    input  rrug_pkg::cmd_t                        q_cmd,
    output logic                                  q_pop,
    input  logic [rrug_pkg::BYTES_W-1:0]          max_service,
    input  logic [$clog2(MAX_CONNS + 1)-1:0]      conn_eff,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output rrug_pkg::res_t                        m_res
);
    import rrug_pkg::*;

    localparam int IW = $clog2(MAX_CONNS);
    localparam int CW = $clog2(MAX_CONNS + 1);

    back_state_t          state_reg, state_next;
    logic [IW-1:0]        last_served_reg;
    logic [IW-1:0]        scan_ptr_reg;
    logic [IW-1:0]        chk_ptr_reg;
    logic                 chk_vld_reg;
    logic [CW-1:0]        issue_left_reg;
    logic [MAX_CONNS-1:0] vld_reg;
    logic                 rd_vld_reg;
    logic                 m_valid_reg;
    res_t                 res_reg;

    logic                 out_free;
    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [IW-1:0]        ram_raddr;
    entry_t               ram_wdata;
    entry_t               ram_rdata;
    entry_t               ent;
    logic [CW-1:0]        ls_ext, ls_inc, sp_inc;
    logic [IW-1:0]        start_ptr, sp_wrap;
    logic                 ls_in_range;
    logic                 seg_hit;
    logic                 scan_hit;
    logic                 scan_done;
    logic [BYTES_W-1:0]   q_bytes;
    logic [BYTES_W-1:0]   q_bytes_capped;

    // status table storage
    rrug_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_CONNS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // entries never written read as zero
    assign ent = rd_vld_reg ? ram_rdata : '0;

    // pointer arithmetic
    always_comb begin
        ls_ext      = CW'(last_served_reg);
        ls_in_range = (ls_ext < conn_eff);
        ls_inc      = ls_ext + 1'b1;
        start_ptr   = (ls_inc >= conn_eff) ? '0 : IW'(ls_inc);
        sp_inc      = CW'(scan_ptr_reg) + 1'b1;
        sp_wrap     = (sp_inc >= conn_eff) ? '0 : IW'(sp_inc);
    end

    // grant sizing and hit detection
    always_comb begin
        q_bytes        = {ent.queue_words, 2'b00};
        q_bytes_capped = (q_bytes > max_service) ? max_service : q_bytes;
        seg_hit        = ls_in_range && ent.seg_running;
        scan_hit       = chk_vld_reg && (ent.queue_words != '0);
        scan_done      = chk_vld_reg && (issue_left_reg == '0);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (q_pop && (q_cmd.opcode == OP_SELECT)) begin
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                state_next = seg_hit ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                if (scan_hit || scan_done) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        out_free  = !m_valid_reg || m_ready;
        q_pop     = 1'b0;
        ram_raddr = last_served_reg;
        case (state_reg)
            S_IDLE:  q_pop = q_valid && out_free;
            S_SCAN:  ram_raddr = scan_ptr_reg;
            default: ram_raddr = last_served_reg;
        endcase
        ram_we                = q_pop && (q_cmd.opcode == OP_UPDATE) && q_cmd.wr_en;
        ram_waddr             = IW'(q_cmd.conn_index);
        ram_wdata.seg_running = q_cmd.seg_running;
        ram_wdata.frag_words  = q_cmd.frag_words;
        ram_wdata.queue_words = q_cmd.queue_words;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // valid bit read alongside the table
    always_ff @(posedge aclk) begin
        rd_vld_reg <= vld_reg[ram_raddr];
    end

    // scan control, pointer, valid bits and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_served_reg <= '0;
            scan_ptr_reg    <= '0;
            chk_ptr_reg     <= '0;
            chk_vld_reg     <= 1'b0;
            issue_left_reg  <= '0;
            vld_reg         <= '0;
            m_valid_reg     <= 1'b0;
            res_reg         <= '0;
        end else begin
            // a taken result leaves unless an update ack replaces it
            if (m_valid_reg && m_ready && !(q_pop && (q_cmd.opcode == OP_UPDATE))) begin
                m_valid_reg <= 1'b0;
            end
            if (ram_we) begin
                vld_reg[ram_waddr] <= 1'b1;
            end
            case (state_reg)
                S_IDLE: begin
                    // update transactions are acknowledged right away
                    if (q_pop && (q_cmd.opcode == OP_UPDATE)) begin
                        m_valid_reg <= 1'b1;
                        res_reg     <= '0;
                    end
                end
                S_LAST: begin
                    if (seg_hit) begin
                        m_valid_reg         <= 1'b1;
                        res_reg.granted     <= 1'b1;
                        res_reg.grant_index <= IDX_W'(last_served_reg);
                        res_reg.grant_bytes <= {ent.frag_words, 2'b00};
                    end else begin
                        last_served_reg <= start_ptr;
                        scan_ptr_reg    <= start_ptr;
                        issue_left_reg  <= conn_eff;
                        chk_vld_reg     <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        m_valid_reg         <= 1'b1;
                        res_reg.granted     <= 1'b1;
                        res_reg.grant_index <= IDX_W'(chk_ptr_reg);
                        res_reg.grant_bytes <= q_bytes_capped;
                        last_served_reg     <= chk_ptr_reg;
                        chk_vld_reg         <= 1'b0;
                    end else if (scan_done) begin
                        m_valid_reg <= 1'b1;
                        res_reg     <= '0;
                        chk_vld_reg <= 1'b0;
                    end else if (issue_left_reg != '0) begin
                        // read one entry a cycle, check it the cycle after
                        chk_ptr_reg    <= scan_ptr_reg;
                        scan_ptr_reg   <= sp_wrap;
                        issue_left_reg <= issue_left_reg - 1'b1;
                        chk_vld_reg    <= 1'b1;
                    end else begin
                        chk_vld_reg <= 1'b0;
                    end
                end
                default: chk_vld_reg <= 1'b0;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = res_reg;

    // checks
    a_update_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && (q_cmd.opcode == OP_UPDATE) |=> m_valid_reg && !res_reg.granted)
        else $error("update transaction not acknowledged");

    a_out_empty_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !m_valid_reg)
        else $error("result register occupied while a select is in flight");

    a_no_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !res_reg.granted |->
            (res_reg.grant_index == '0) && (res_reg.grant_bytes == '0))
        else $error("no-grant result carries index or bytes");

    a_ptr_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_served_reg != $past(last_served_reg)) |->
            ($past(state_reg) == S_LAST) || ($past(state_reg) == S_SCAN))
        else $error("last-served pointer moved outside a select");

endmodule

// ===== hw/rtl/round_robin_upstream_grant_core.sv =====
// round_robin_upstream_grant_core: top level, configuration registers and the
// front / command queue / back split; depends on rrug_pkg, rrug_front, rrug_back
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    opcode, conn_index, queue/frag words, seg flag
//   m_       out        m_valid / m_ready    granted, grant_index, grant_bytes
//   cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// an update transaction passes through the command queue to the result register
// a select first reads the last-served connection and grants it if it is segmenting, else
// it scans onward from the next connection, a distance of 0..conn_count-1; the table RAM
// read port, one entry per cycle, sets the scan length
// reset clears the table through per-entry valid bits, no clearing pass
// the queue takes transactions while the back end scans or its result waits
module round_robin_upstream_grant_core #(
    parameter int MAX_CONNS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic [rrug_pkg::IDX_W-1:0]        s_conn_index,
    input  logic [rrug_pkg::WORDS_W-1:0]      s_queue_words,
    input  logic [rrug_pkg::WORDS_W-1:0]      s_frag_words,
    input  logic                              s_seg_running,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_granted,
    output logic [rrug_pkg::IDX_W-1:0]        m_grant_index,
    output logic [rrug_pkg::BYTES_W-1:0]      m_grant_bytes,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rrug_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrug_pkg::BYTES_W-1:0]      cfg_data
);
    import rrug_pkg::*;

    localparam int CW = $clog2(MAX_CONNS + 1);

    logic [BYTES_W-1:0] max_service_reg;
    logic [CW-1:0]      conn_eff_reg;
    logic [CNT_W-1:0]   cfg_count;
    logic [CW-1:0]      cfg_count_eff;
    logic               q_valid;
    logic               q_pop;
    cmd_t               q_cmd;
    res_t               m_res;

    // connection count from the low CNT_W bits of cfg_data: zero reads as one, values above MAX_CONNS saturate
    always_comb begin
        cfg_count = cfg_data[CNT_W-1:0];
        if (cfg_count == '0) begin
            cfg_count_eff = CW'(1);
        end else if (32'(cfg_count) > MAX_CONNS) begin
            cfg_count_eff = CW'(MAX_CONNS);
        end else begin
            cfg_count_eff = CW'(cfg_count);
        end
    end

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_service_reg <= MAX_SERVICE_RESET;
            conn_eff_reg    <= CW'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MAX_SERVICE: max_service_reg <= cfg_data;
                REG_CONN_COUNT:  conn_eff_reg    <= cfg_count_eff;
                default: ;
            endcase
        end
    end

    rrug_front #(
        .MAX_CONNS (MAX_CONNS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_conn_index  (s_conn_index),
        .s_queue_words (s_queue_words),
        .s_frag_words  (s_frag_words),
        .s_seg_running (s_seg_running),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop)
    );

    rrug_back #(
        .MAX_CONNS (MAX_CONNS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .max_service (max_service_reg),
        .conn_eff    (conn_eff_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_res       (m_res)
    );

    assign m_granted     = m_res.granted;
    assign m_grant_index = m_res.grant_index;
    assign m_grant_bytes = m_res.grant_bytes;

endmodule
